/* src/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// operation codes, command classes, status codes and the result record
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int CAPACITY_DEFAULT  = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed port field widths
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FPOS_W   = 6;
   localparam int LEN_W    = 7;

   // depth of the command queue between front and back
   localparam int CMD_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_REMOVE = 3'd4,
      OP_FIND   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      K_APPEND,
      K_INSERT,
      K_GET,
      K_SET,
      K_REMOVE,
      K_FIND,
      K_CLEAR,
      K_NOP
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  position;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] read_word;
      logic              found;
      logic [FPOS_W-1:0] found_position;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
   } rsp_type;

endpackage

/* src/ile_front.sv */
// ----------------------------------------------------------------------------
// ile_front: request decoder
// takes request transactions, classifies the op code and zero extends or cuts the data word
// to the stored word width before it enters the command queue
// ----------------------------------------------------------------------------
module ile_front #(
   parameter int WORD_BITS = ile_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        req_push,
   input  logic [ile_pkg::OP_W-1:0]    req_op,
   input  logic [ile_pkg::POS_W-1:0]   req_position,
   input  logic [ile_pkg::DATA_W-1:0]  req_data_word,
   input  logic                        queue_full,
   output logic                        queue_push,
   output ile_pkg::cmd_type            cmd,
   output logic [WORD_BITS-1:0]        cmd_word
);
   import ile_pkg::*;

   kind_type kind;

   always_comb begin
      unique case (req_op)
         OP_APPEND: kind = K_APPEND;
         OP_INSERT: kind = K_INSERT;
         OP_GET:    kind = K_GET;
         OP_SET:    kind = K_SET;
         OP_REMOVE: kind = K_REMOVE;
         OP_FIND:   kind = K_FIND;
         OP_CLEAR:  kind = K_CLEAR;
         default:   kind = K_NOP;
      endcase
   end

   assign queue_push    = req_push && !queue_full;
   assign cmd.kind      = kind;
   assign cmd.position  = req_position;
   // zero extends or cuts to the stored width
   assign cmd_word      = WORD_BITS'(req_data_word);

endmodule

/* src/ile_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ile_cmd_fifo: command queue
// short queue between the decoder and the list sequencer
// ----------------------------------------------------------------------------
module ile_cmd_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              pop,
   output logic [DATA_W-1:0] rd_data,
   output logic              full,
   output logic              not_empty
);
   import ile_pkg::*;

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CMD_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   assign full      = (fill_ff == CNT_W'(CMD_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign rd_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("command queue written while full");

   fifo_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command queue read while empty");

   fifo_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CMD_DEPTH))
      else $error("command queue fill above depth");

endmodule

/* src/ile_back.sv */
// ----------------------------------------------------------------------------
// ile_back: list sequencer
// owns the entry memory and the length, executes one command at a time by
// stepping through the memory, and holds the result until it is taken
// ----------------------------------------------------------------------------
module ile_back #(
   parameter int CAPACITY  = ile_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = ile_pkg::WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  ile_pkg::cmd_type      cmd,
   input  logic [WORD_BITS-1:0]  cmd_word,
   output logic                  cmd_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_valid,
   output ile_pkg::rsp_type      rsp
);
   import ile_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_UP_RD    = 9'b000000010,
      ST_UP_WR    = 9'b000000100,
      ST_UP_FIN   = 9'b000001000,
      ST_GET_WAIT = 9'b000010000,
      ST_RM_WAIT  = 9'b000100000,
      ST_DN_RD    = 9'b001000000,
      ST_DN_WR    = 9'b010000000,
      ST_FIND_CMP = 9'b100000000
   } state_type;

   logic [WORD_BITS-1:0] mem [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 res_valid_ff, res_valid_in;
   rsp_type              res_ff, res_in;

   logic                 done;
   status_type           done_status;
   logic [WORD_BITS-1:0] done_word;
   logic                 done_found;
   logic [CNT_W-1:0]     done_fpos;

   logic [CMP_W-1:0]     pos_wide, cnt_wide;
   logic                 list_full;
   logic [CNT_W-1:0]     idx_inc, idx_dec, count_inc, count_dec;

   assign pos_wide  = CMP_W'(cmd.position);
   assign cnt_wide  = CMP_W'(count_ff);
   assign list_full = (count_ff == CNT_W'(CAPACITY));
   assign idx_inc   = idx_ff + 1'b1;
   assign idx_dec   = idx_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      word_in     = word_ff;
      cmd_pop     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = word_ff;
      done        = 1'b0;
      done_status = STATUS_OK;
      done_word   = '0;
      done_found  = 1'b0;
      done_fpos   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // start only with the result slot free
            if (cmd_valid && !res_valid_ff) begin
               cmd_pop = 1'b1;
               pos_in  = IDX_W'(cmd.position);
               word_in = cmd_word;
               unique case (cmd.kind) inside
                  K_APPEND: begin
                     done = 1'b1;
                     if (list_full) begin
                        done_status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = cmd_word;
                        count_in = count_inc;
                     end
                  end
                  K_INSERT, K_SET: begin
                     if (cmd.kind == K_SET && pos_wide < cnt_wide) begin
                        // overwrite in place
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(cmd.position);
                        wr_data = cmd_word;
                        done    = 1'b1;
                     end else if (pos_wide > cnt_wide) begin
                        done        = 1'b1;
                        done_status = STATUS_RANGE;
                     end else if (list_full) begin
                        done        = 1'b1;
                        done_status = STATUS_FULL;
                     end else if (pos_wide == cnt_wide) begin
                        wr_en    = 1'b1;
                        wr_addr  = IDX_W'(cmd.position);
                        wr_data  = cmd_word;
                        count_in = count_inc;
                        done     = 1'b1;
                     end else begin
                        // move the tail up one entry, top first
                        idx_in   = count_ff;
                        state_in = ST_UP_RD;
                     end
                  end
                  K_GET: begin
                     if (pos_wide < cnt_wide) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(cmd.position);
                        state_in = ST_GET_WAIT;
                     end else begin
                        done        = 1'b1;
                        done_status = STATUS_RANGE;
                     end
                  end
                  K_REMOVE: begin
                     if (pos_wide < cnt_wide) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(cmd.position);
                        idx_in   = CNT_W'(cmd.position);
                        state_in = ST_RM_WAIT;
                     end else begin
                        done        = 1'b1;
                        done_status = STATUS_RANGE;
                     end
                  end
                  K_FIND: begin
                     if (count_ff == '0) begin
                        done = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = ST_FIND_CMP;
                     end
                  end
                  K_CLEAR: begin
                     count_in = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_dec[IDX_W-1:0];
            state_in = ST_UP_WR;
         end
         ST_UP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_dec;
            state_in = (idx_dec == CNT_W'(pos_ff)) ? ST_UP_FIN : ST_UP_RD;
         end
         ST_UP_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = word_ff;
            count_in = count_inc;
            done     = 1'b1;
         end
         ST_GET_WAIT: begin
            done_word = rd_data_ff;
            done      = 1'b1;
         end
         ST_RM_WAIT: begin
            // keep the removed word while the tail moves down
            word_in = rd_data_ff;
            if (idx_ff == count_dec) begin
               count_in  = count_dec;
               done_word = rd_data_ff;
               done      = 1'b1;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_inc[IDX_W-1:0];
            state_in = ST_DN_WR;
         end
         ST_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            idx_in  = idx_inc;
            if (idx_inc == count_dec) begin
               count_in  = count_dec;
               done_word = word_ff;
               done      = 1'b1;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_FIND_CMP: begin
            // rd_data_ff holds the entry at idx_ff
            if (rd_data_ff == word_ff) begin
               done_found = 1'b1;
               done_fpos  = idx_ff;
               done       = 1'b1;
            end else if (idx_inc == count_ff) begin
               done = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_inc[IDX_W-1:0];
               idx_in  = idx_inc;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end
   end

   always_comb begin
      res_in                = res_ff;
      res_valid_in          = res_valid_ff;
      if (done) begin
         res_valid_in          = 1'b1;
         res_in.status         = done_status;
         res_in.read_word      = DATA_W'(done_word);
         res_in.found          = done_found;
         res_in.found_position = FPOS_W'(done_fpos);
         res_in.length         = LEN_W'(count_in);
         res_in.is_empty       = (count_in == '0);
      end else if (rsp_pop) begin
         res_valid_in = 1'b0;
      end
   end

   assign rsp_valid = res_valid_ff;
   assign rsp       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      word_ff <= word_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   back_slot_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !res_valid_ff)
      else $error("result written over a waiting transaction");

   back_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   back_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) && count_ff != '0 |->
         count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1)
      else $error("list length moved by more than one entry");

   back_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid && state_ff == ST_IDLE)
      else $error("command taken outside idle");

endmodule

/* src/indexed_list_engine.sv */
// a request is registered in the command queue, taken by the sequencer when idle, and its
// result registered in the result slot; get adds a memory read, insert and remove shift the
// tail one entry per step, find compares entries in order; one operation at a time, and the
// next starts once the result is taken. reset clears the length, the command queue and the
// result slot; entries are not cleared and the block takes requests as soon as reset is
// released; two requests queue while an operation runs.
// ----------------------------------------------------------------------------
// indexed_list_engine: bounded ordered list of data words
// a decoder and a command queue feed a sequencer that shifts, reads and
// searches the entry memory one entry per step
// ----------------------------------------------------------------------------
module indexed_list_engine #(
   parameter int CAPACITY  = ile_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = ile_pkg::WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ile_pkg::OP_W-1:0]      req_op,
   input  logic [ile_pkg::POS_W-1:0]     req_position,
   input  logic [ile_pkg::DATA_W-1:0]    req_data_word,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ile_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ile_pkg::DATA_W-1:0]    rsp_read_word,
   output logic                          rsp_found,
   output logic [ile_pkg::FPOS_W-1:0]    rsp_found_position,
   output logic [ile_pkg::LEN_W-1:0]     rsp_length,
   output logic                          rsp_is_empty
);
   import ile_pkg::*;

   localparam int QUEUE_W = $bits(cmd_type) + WORD_BITS;

   logic                 queue_full;
   logic                 queue_push;
   logic                 queue_pop;
   logic                 queue_not_empty;
   cmd_type              front_cmd, back_cmd;
   logic [WORD_BITS-1:0] front_word, back_word;
   logic [QUEUE_W-1:0]   queue_rd_data;
   logic                 rsp_valid;
   rsp_type              rsp;

   ile_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .req_push      (req_push),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_data_word (req_data_word),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .cmd           (front_cmd),
      .cmd_word      (front_word)
   );

   ile_cmd_fifo #(
      .DATA_W (QUEUE_W)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .wr_data   ({front_cmd, front_word}),
      .pop       (queue_pop),
      .rd_data   (queue_rd_data),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   assign {back_cmd, back_word} = queue_rd_data;

   ile_back #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (back_cmd),
      .cmd_word  (back_word),
      .cmd_pop   (queue_pop),
      .rsp_pop   (rsp_pop && rsp_valid),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign req_full           = queue_full;
   assign rsp_empty          = !rsp_valid;
   assign rsp_status         = rsp.status;
   assign rsp_read_word      = rsp.read_word;
   assign rsp_found          = rsp.found;
   assign rsp_found_position = rsp.found_position;
   assign rsp_length         = rsp.length;
   assign rsp_is_empty       = rsp.is_empty;

endmodule
